/* rtl/itp_pkg.sv */
// ----------------------------------------------------------------------------
// Integer text parser package
// Types, character codes and the digit decoder that the parser modules share.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int ACC_W  = 64;
    localparam int BASE_W = 6;
    localparam int PROD_W = ACC_W + BASE_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LZ      = 8'h7a;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UZ      = 8'h5a;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_US      = 8'h5f;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_O       = 8'h6f;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CASE_BIT   = 8'h20;
    localparam logic [7:0] LETTER_OFS = 8'd10;

    localparam logic [BASE_W-1:0] BASE_BIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
    localparam logic [BASE_W-1:0] DIGIT_NONE = 6'd36;
    localparam logic [BASE_W-1:0] RADIX_RST  = BASE_DEC;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_VALUE = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_BODY   = 3'd3
    } t_phase;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_MUL  = 2'd1,
        CS_UPD  = 2'd2
    } t_ctrl_state;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
        logic       no_char;
    } t_in_item;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic [1:0]              status;
    } t_out_item;

    typedef struct packed {
        t_phase              phase;
        logic                neg;
        logic [BASE_W-1:0]   base;
        logic [ACC_W-1:0]    acc;
        logic                digit_seen;
        logic                us_ok;
        logic                last_us;
        logic                check_lz;
        logic                lz;
        logic                nonzero;
        t_status             err;
    } t_parse_state;

    localparam t_parse_state PS_CLEAR = '{
        phase: PH_START,
        err: ST_OK,
        default: '0
    };

    typedef struct packed {
        logic load_item;
        logic load_prod;
        logic commit;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic item_last;
    } t_sts;

    function automatic logic [BASE_W-1:0] digit_of(input logic [7:0] c);
        logic [BASE_W-1:0] d;
        if (c >= CH_0 && c <= CH_9) begin
            d = BASE_W'(c - CH_0);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = BASE_W'(c - CH_LA + LETTER_OFS);
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d = BASE_W'(c - CH_UA + LETTER_OFS);
        end else begin
            d = DIGIT_NONE;
        end
        return d;
    endfunction

endpackage

/* rtl/itp_ctrl.sv */
// ----------------------------------------------------------------------------
// Integer text parser controller
// Sequences each request through multiply and update, and owns output valid.
// ----------------------------------------------------------------------------
module itp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    input  itp_pkg::t_sts i_sts,
    output itp_pkg::t_cmd o_cmd
);

    itp_pkg::t_ctrl_state r_state;
    itp_pkg::t_ctrl_state n_state;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itp_pkg::CS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            itp_pkg::CS_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = itp_pkg::CS_MUL;
                end
            end
            itp_pkg::CS_MUL: begin
                o_cmd.load_prod = 1'b1;
                n_state         = itp_pkg::CS_UPD;
            end
            itp_pkg::CS_UPD: begin
                if (!i_sts.item_last || out_free) begin
                    o_cmd.commit   = 1'b1;
                    o_cmd.load_out = i_sts.item_last;
                    o_in_stall     = 1'b0;
                    if (i_in_valid) begin
                        o_cmd.load_item = 1'b1;
                        n_state         = itp_pkg::CS_MUL;
                    end else begin
                        n_state = itp_pkg::CS_IDLE;
                    end
                end
            end
            default: begin
                n_state = itp_pkg::CS_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

/* rtl/itp_datapath.sv */
// ----------------------------------------------------------------------------
// Integer text parser datapath
// Holds the radix, the parse state, the product register and the result.
// ----------------------------------------------------------------------------
module itp_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [itp_pkg::BASE_W-1:0]    i_cfg_data,
    input  itp_pkg::t_in_item             i_in_data,
    input  itp_pkg::t_cmd                 i_cmd,
    output itp_pkg::t_sts                 o_sts,
    output itp_pkg::t_out_item            o_out_data
);

    logic [itp_pkg::BASE_W-1:0] r_radix;
    itp_pkg::t_in_item          r_item;
    logic [itp_pkg::PROD_W-1:0] r_prod;
    itp_pkg::t_parse_state      r_st;
    itp_pkg::t_parse_state      n_st;
    itp_pkg::t_out_item         r_out;
    itp_pkg::t_out_item         n_out;
    logic [itp_pkg::BASE_W-1:0] base_eff;
    itp_pkg::t_parse_state      st_latched;
    itp_pkg::t_parse_state      st_taken;
    itp_pkg::t_parse_state      st_end;
    itp_pkg::t_status           status;
    logic                       ignore_item;

    function automatic itp_pkg::t_parse_state body_char(
        input itp_pkg::t_parse_state      s,
        input logic [7:0]                 c,
        input logic [itp_pkg::PROD_W-1:0] prod
    );
        itp_pkg::t_parse_state      r;
        logic [itp_pkg::BASE_W-1:0] d;
        logic [itp_pkg::SUM_W-1:0]  sum;
        logic [itp_pkg::SUM_W-1:0]  limit;
        r     = s;
        d     = itp_pkg::digit_of(c);
        sum   = {1'b0, prod} + itp_pkg::SUM_W'(d);
        limit = s.neg ? itp_pkg::SUM_W'({1'b1, {(itp_pkg::ACC_W-1){1'b0}}})
                      : itp_pkg::SUM_W'({1'b0, {(itp_pkg::ACC_W-1){1'b1}}});
        if (r.err != itp_pkg::ST_VALUE) begin
            if (r.base == '0) begin
                r.base     = itp_pkg::BASE_DEC;
                r.check_lz = 1'b1;
            end
            if (c == itp_pkg::CH_US) begin
                if (!r.us_ok) begin
                    r.err = itp_pkg::ST_VALUE;
                end else begin
                    r.us_ok   = 1'b0;
                    r.last_us = 1'b1;
                end
            end else if (r.base < itp_pkg::BASE_BIN || d >= r.base) begin
                r.err = itp_pkg::ST_VALUE;
            end else begin
                if (!r.digit_seen) begin
                    r.digit_seen = 1'b1;
                    if (d == '0) begin
                        r.lz = 1'b1;
                    end
                end
                if (d != '0) begin
                    r.nonzero = 1'b1;
                end
                if (r.err == itp_pkg::ST_OK) begin
                    if (sum > limit) begin
                        r.err = itp_pkg::ST_OVER;
                    end else begin
                        r.acc = sum[itp_pkg::ACC_W-1:0];
                    end
                end
                r.us_ok   = 1'b1;
                r.last_us = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic itp_pkg::t_parse_state take_char(
        input itp_pkg::t_parse_state      s,
        input logic [7:0]                 c,
        input logic [itp_pkg::PROD_W-1:0] prod
    );
        itp_pkg::t_parse_state      r;
        logic [7:0]                 m;
        logic [itp_pkg::BASE_W-1:0] pb;
        r = s;
        m = c | itp_pkg::CASE_BIT;
        if (m == itp_pkg::CH_X) begin
            pb = itp_pkg::BASE_HEX;
        end else if (m == itp_pkg::CH_O) begin
            pb = itp_pkg::BASE_OCT;
        end else if (m == itp_pkg::CH_B) begin
            pb = itp_pkg::BASE_BIN;
        end else begin
            pb = '0;
        end
        if (s.phase == itp_pkg::PH_START || s.phase == itp_pkg::PH_SIGNED) begin
            if (c == itp_pkg::CH_0) begin
                r.phase = itp_pkg::PH_ZERO;
            end else if (s.phase == itp_pkg::PH_START
                         && (c == itp_pkg::CH_PLUS || c == itp_pkg::CH_MINUS)) begin
                r.neg   = (c == itp_pkg::CH_MINUS);
                r.phase = itp_pkg::PH_SIGNED;
            end else begin
                r       = body_char(r, c, prod);
                r.phase = itp_pkg::PH_BODY;
            end
        end else if (s.phase == itp_pkg::PH_ZERO) begin
            if (pb != '0 && s.err == itp_pkg::ST_OK && (s.base == '0 || s.base == pb)) begin
                r.base  = pb;
                r.us_ok = 1'b1;
            end else begin
                r = body_char(r, itp_pkg::CH_0, prod);
                r = body_char(r, c, prod);
            end
            r.phase = itp_pkg::PH_BODY;
        end else begin
            r = body_char(r, c, prod);
        end
        return r;
    endfunction

    // The accumulator is still zero whenever a held-back zero is replayed, so
    // the one registered product serves every digit of a request.
    assign base_eff = (r_st.base == '0) ? itp_pkg::BASE_DEC : r_st.base;

    always_comb begin
        st_latched = r_st;
        if (r_st.phase == itp_pkg::PH_START) begin
            st_latched.base = r_radix;
            if (r_radix == itp_pkg::BASE_ONE || r_radix > itp_pkg::BASE_MAX) begin
                st_latched.err = itp_pkg::ST_VALUE;
            end
        end
        if (r_item.no_char) begin
            st_taken = st_latched;
        end else begin
            st_taken = take_char(st_latched, r_item.char_code, r_prod);
        end
        if (st_taken.phase == itp_pkg::PH_ZERO) begin
            st_end = body_char(st_taken, itp_pkg::CH_0, r_prod);
        end else begin
            st_end = st_taken;
        end
    end

    always_comb begin
        if (st_end.err == itp_pkg::ST_VALUE || !st_end.digit_seen || st_end.last_us
            || (st_end.check_lz && st_end.lz && st_end.nonzero)) begin
            status = itp_pkg::ST_VALUE;
        end else if (st_end.err == itp_pkg::ST_OVER) begin
            status = itp_pkg::ST_OVER;
        end else begin
            status = itp_pkg::ST_OK;
        end
        n_out.status = status;
        if (status == itp_pkg::ST_OK) begin
            n_out.value = st_end.neg ? ({itp_pkg::ACC_W{1'b0}} - st_end.acc) : st_end.acc;
        end else begin
            n_out.value = '0;
        end
    end

    assign ignore_item = r_item.no_char && !r_item.is_last;

    always_comb begin
        if (ignore_item) begin
            n_st = r_st;
        end else if (r_item.is_last) begin
            n_st = itp_pkg::PS_CLEAR;
        end else begin
            n_st = st_taken;
        end
    end

    assign o_sts.item_last = r_item.is_last;
    assign o_out_data      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= itp_pkg::RADIX_RST;
            r_st    <= itp_pkg::PS_CLEAR;
        end else begin
            if (i_cfg_valid) begin
                r_radix <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_st <= n_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.load_prod) begin
            r_prod <= itp_pkg::PROD_W'(r_st.acc) * itp_pkg::PROD_W'(base_eff);
        end
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

endmodule

/* rtl/int_text_parser.sv */
// ----------------------------------------------------------------------------
// Integer text parser
// Each character passes first through the 64 by 6 bit multiplier register,
// then through the add, the overflow compare and the state update.
// The last request's update loads the result once the output register is free.
// A new request is taken while a finished result waits to be read.
// Synchronous reset sets the radix to ten, clears the parse state and
// drops any pending result.
// ----------------------------------------------------------------------------
module int_text_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  itp_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output itp_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [itp_pkg::BASE_W-1:0] i_cfg_data
);

    itp_pkg::t_cmd cmd;
    itp_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    itp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    itp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_out_data)
    );

    a_accept_then_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> cmd.load_prod)
        else $error("Accepted request was not followed by a multiply.");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !(o_out_valid && i_out_stall))
        else $error("Pending result overwritten.");

    a_error_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != itp_pkg::ST_OK) |-> (o_out_data.value == '0))
        else $error("Non-zero value with error status.");

    a_commit_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> $past(o_in_stall))
        else $error("Update without a multiply before it.");

endmodule
